[src/bmprgb_pkg.sv]
// Shared types and constants for the BMP stream to rotated RGB565 block.
// No dependencies; used by every design module of the block (not by bmprgb_chk).
package bmprgb_pkg;

    // APB register map: index = paddr[4:2]
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION_MODE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd4;

    // result kinds and error codes
    localparam logic       EV_PIXEL  = 1'b0;
    localparam logic       EV_REJECT = 1'b1;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SIGNATURE = 2'd1;
    localparam logic [1:0] ERR_PLANES    = 2'd2;
    localparam logic [1:0] ERR_FORMAT    = 2'd3;

    // quarter-turn codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // header constants
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] DEPTH_16      = 16'd16;
    localparam logic [15:0] DEPTH_24      = 16'd24;
    localparam logic [31:0] HEADER_END    = 32'd34;

    localparam logic [7:0] RST_DISPLAY_SIDE = 8'd128;

    typedef struct packed {
        logic [7:0] display_width;
        logic [7:0] display_height;
        logic [1:0] rotation_mode;
        logic [6:0] origin_x;
        logic [6:0] origin_y;
    } t_cfg;

    // control of one event between parser and placement stage
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [1:0] err;
        logic       last;
        logic [1:0] rot;
    } t_mid;

endpackage

[src/bmp_stream_to_rotated_rgb565_top.sv]
// A result is registered first in the parse stage and then in the result register.
// Throughput: one file byte per cycle; the parse stage and the result register advance
// together, so the input stalls only while a result waits in the output register.
// Reset (i_rst_n low, synchronous): parser back to the signature phase, registers to a
// 128x128 panel, no rotation, origin 0, and the pipeline emptied.
// Depends on bmprgb_pkg, bmprgb_cfg, bmprgb_parse, bmprgb_place.
module bmp_stream_to_rotated_rgb565_top #(
    parameter int MAX_SIDE = 128    // largest panel side, up to 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte stream in
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] file_byte
    input  logic                          i_s_axis_tuser,   // [0] first_of_file
    // events out
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [1:0] error_code, [15:2] pixel_index, [31:16] pixel_color,
    // [39:32] crop_width, [47:40] crop_height
    output logic [47:0]                   o_m_axis_tdata,
    output logic                          o_m_axis_tuser,   // [0] event_kind
    output logic                          o_m_axis_tlast,   // last_pixel
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmprgb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW = $clog2(MAX_SIDE + 1);

    bmprgb_pkg::t_cfg w_cfg;
    bmprgb_pkg::t_mid w_mid;
    logic [CW-1:0]    w_col, w_row, w_cw, w_ch;
    logic [15:0]      w_mid_color;
    logic             w_adv;
    logic             w_kind, w_last;
    logic [1:0]       w_err;
    logic [13:0]      w_index;
    logic [15:0]      w_color;
    logic [7:0]       w_cw8, w_ch8;

    // whole pipeline moves whenever the result register is free or being drained
    assign w_adv           = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    bmprgb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // stage 1: header fields, row/pixel counters, crop test
    bmprgb_parse #(.MAX_SIDE(MAX_SIDE)) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_first (i_s_axis_tuser),
        .i_cfg   (w_cfg),
        .o_ctl   (w_mid),
        .o_col   (w_col),
        .o_row   (w_row),
        .o_cw    (w_cw),
        .o_ch    (w_ch),
        .o_color (w_mid_color)
    );

    // stage 2: rotation, row*width+col, result register
    bmprgb_place #(.MAX_SIDE(MAX_SIDE)) u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_mid),
        .i_col   (w_col),
        .i_row   (w_row),
        .i_cw    (w_cw),
        .i_ch    (w_ch),
        .i_color (w_mid_color),
        .o_valid (o_m_axis_tvalid),
        .o_kind  (w_kind),
        .o_err   (w_err),
        .o_index (w_index),
        .o_color (w_color),
        .o_cw    (w_cw8),
        .o_ch    (w_ch8),
        .o_last  (w_last)
    );

    assign o_m_axis_tdata = {w_ch8, w_cw8, w_color, w_index, w_err};
    assign o_m_axis_tuser = w_kind;
    assign o_m_axis_tlast = w_last;

endmodule

[src/bmprgb_cfg.sv]
// APB register file holding panel size, rotation and image origin.
// Depends on bmprgb_pkg.
module bmprgb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmprgb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output bmprgb_pkg::t_cfg              o_cfg
);

    bmprgb_pkg::t_cfg                    r_cfg;
    logic [bmprgb_pkg::REG_IDX_W-1:0]    w_idx;
    logic                                w_wr;

    assign w_idx  = paddr[bmprgb_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_width  <= bmprgb_pkg::RST_DISPLAY_SIDE;
            r_cfg.display_height <= bmprgb_pkg::RST_DISPLAY_SIDE;
            r_cfg.rotation_mode  <= bmprgb_pkg::ROT_0;
            r_cfg.origin_x       <= '0;
            r_cfg.origin_y       <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                bmprgb_pkg::REG_DISPLAY_WIDTH:  r_cfg.display_width  <= pwdata[7:0];
                bmprgb_pkg::REG_DISPLAY_HEIGHT: r_cfg.display_height <= pwdata[7:0];
                bmprgb_pkg::REG_ROTATION_MODE:  r_cfg.rotation_mode  <= pwdata[1:0];
                bmprgb_pkg::REG_ORIGIN_X:       r_cfg.origin_x       <= pwdata[6:0];
                bmprgb_pkg::REG_ORIGIN_Y:       r_cfg.origin_y       <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bmprgb_pkg::REG_DISPLAY_WIDTH:  prdata = {24'd0, r_cfg.display_width};
            bmprgb_pkg::REG_DISPLAY_HEIGHT: prdata = {24'd0, r_cfg.display_height};
            bmprgb_pkg::REG_ROTATION_MODE:  prdata = {30'd0, r_cfg.rotation_mode};
            bmprgb_pkg::REG_ORIGIN_X:       prdata = {25'd0, r_cfg.origin_x};
            bmprgb_pkg::REG_ORIGIN_Y:       prdata = {25'd0, r_cfg.origin_y};
            default:                        prdata = 32'd0;
        endcase
    end

endmodule

[src/bmprgb_parse.sv]
// Header parser, pixel assembler and crop check; registers at most one event per byte.
// Depends on bmprgb_pkg.
module bmprgb_parse #(
    parameter int MAX_SIDE = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [7:0]                  i_byte,
    input  logic                        i_first,
    input  bmprgb_pkg::t_cfg            i_cfg,
    output bmprgb_pkg::t_mid            o_ctl,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_col,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_row,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_cw,
    output logic [$clog2(MAX_SIDE+1)-1:0] o_ch,
    output logic [15:0]                 o_color
);

    localparam int CW = $clog2(MAX_SIDE + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_REJECT = 3'd5;

    // position of the last byte of each header field
    localparam logic [31:0] POS_SIG    = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_PLANES = 32'd27;
    localparam logic [31:0] POS_DEPTH  = 32'd29;
    localparam logic [31:0] POS_COMP   = 32'd33;

    function automatic logic [CW-1:0] clamp_side(input logic [7:0] v);
        return (32'(v) > 32'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(v);
    endfunction

    function automatic logic [CW-1:0] crop_len(input logic [31:0] img,
                                               input logic [6:0]  org,
                                               input logic [CW-1:0] panel);
        logic [CW-1:0] room;
        if (32'(org) >= 32'(panel)) begin
            return '0;
        end
        room = panel - CW'(org);
        return (img < 32'(room)) ? CW'(img) : room;
    endfunction

    // parser state
    logic [2:0]  r_phase, c_phase, n_phase;
    logic [31:0] r_bpos,  c_bpos,  n_bpos;
    logic [31:0] r_fa,    c_fa,    n_fa;
    logic [31:0] r_off,   c_off,   n_off;
    logic [31:0] r_w,     c_w,     n_w;
    logic [31:0] r_h,     c_h,     n_h;
    logic        r_td,    c_td,    n_td;
    logic        r_deep,  c_deep,  n_deep;
    logic [15:0] r_pa,    c_pa,    n_pa;
    logic [1:0]  r_bip,   c_bip,   n_bip;
    logic [31:0] r_bir,   c_bir,   n_bir;
    logic [31:0] r_frow,  c_frow,  n_frow;

    // event stage
    bmprgb_pkg::t_mid r_ctl;
    logic [CW-1:0]    r_col, r_row, r_cw, r_ch;
    logic [15:0]      r_color;

    logic [31:0]   hdr_fa, hgt_mag, row32, bir_inc;
    logic [CW-1:0] pw, ph, cw, ch, col_n, row_n;
    logic          org_in, pix_in, pix_go, row_end, do_rej, emit;
    logic [1:0]    rej_code, need, pad_mod, pad;
    logic [15:0]   px_color;
    logic          e_kind, e_last;
    logic [1:0]    e_err;

    // first_of_file makes this byte see a freshly reset parser
    always_comb begin
        c_phase = i_first ? PH_HEADER : r_phase;
        c_bpos  = i_first ? 32'd0 : r_bpos;
        c_fa    = i_first ? 32'd0 : r_fa;
        c_off   = i_first ? 32'd0 : r_off;
        c_w     = i_first ? 32'd0 : r_w;
        c_h     = i_first ? 32'd0 : r_h;
        c_td    = i_first ? 1'b0  : r_td;
        c_deep  = i_first ? 1'b0  : r_deep;
        c_pa    = i_first ? 16'd0 : r_pa;
        c_bip   = i_first ? 2'd0  : r_bip;
        c_bir   = i_first ? 32'd0 : r_bir;
        c_frow  = i_first ? 32'd0 : r_frow;
    end

    // crop window and position of the current pixel
    always_comb begin
        pw     = clamp_side(i_cfg.display_width);
        ph     = clamp_side(i_cfg.display_height);
        org_in = (32'(i_cfg.origin_x) < 32'(pw)) && (32'(i_cfg.origin_y) < 32'(ph));
        cw     = crop_len(c_w, i_cfg.origin_x, pw);
        ch     = crop_len(c_h, i_cfg.origin_y, ph);
        row32  = c_td ? c_frow : (c_h - 32'd1 - c_frow);
        pix_in = (c_bir < 32'(cw)) && (row32 < 32'(ch));
        col_n  = CW'(c_bir);
        row_n  = CW'(row32);
        e_last = (col_n == cw - CW'(1)) &&
                 (c_td ? (row_n == ch - CW'(1)) : (row_n == '0));
        need    = c_deep ? 2'd2 : 2'd1;
        pad_mod = c_deep ? 2'(c_w[1:0] * 2'd3) : {c_w[0], 1'b0};
        pad     = 2'(2'd0 - pad_mod);
        hgt_mag = c_h[31] ? (~c_h + 32'd1) : c_h;
        hdr_fa  = {i_byte, c_fa[31:8]};
        bir_inc = c_bir + 32'd1;
    end

    always_comb begin
        n_phase = c_phase; n_bpos = c_bpos; n_fa = c_fa; n_off = c_off;
        n_w = c_w; n_h = c_h; n_td = c_td; n_deep = c_deep; n_pa = c_pa;
        n_bip = c_bip; n_bir = c_bir; n_frow = c_frow;
        pix_go = 1'b0; row_end = 1'b0; do_rej = 1'b0; rej_code = bmprgb_pkg::ERR_NONE;
        emit = 1'b0; e_kind = bmprgb_pkg::EV_PIXEL; e_err = bmprgb_pkg::ERR_NONE;
        px_color = c_pa;

        unique case (c_phase)
            PH_HEADER: begin
                n_fa   = hdr_fa;
                n_bpos = c_bpos + 32'd1;
                unique case (c_bpos)
                    POS_SIG: begin
                        if (hdr_fa[31:16] != bmprgb_pkg::BMP_SIGNATURE) begin
                            do_rej = 1'b1; rej_code = bmprgb_pkg::ERR_SIGNATURE;
                        end
                    end
                    POS_OFFSET: n_off = hdr_fa;
                    POS_WIDTH:  n_w   = hdr_fa;
                    POS_HEIGHT: n_h   = hdr_fa;
                    POS_PLANES: begin
                        if (hdr_fa[31:16] != 16'd1) begin
                            do_rej = 1'b1; rej_code = bmprgb_pkg::ERR_PLANES;
                        end
                    end
                    POS_DEPTH: begin
                        if (hdr_fa[31:16] == bmprgb_pkg::DEPTH_24) begin
                            n_deep = 1'b1;
                        end else if (hdr_fa[31:16] == bmprgb_pkg::DEPTH_16) begin
                            n_deep = 1'b0;
                        end else begin
                            do_rej = 1'b1; rej_code = bmprgb_pkg::ERR_FORMAT;
                        end
                    end
                    POS_COMP: begin
                        if (hdr_fa != 32'd0) begin
                            do_rej = 1'b1; rej_code = bmprgb_pkg::ERR_FORMAT;
                        end else begin
                            // negative height: top-down rows
                            n_td = c_h[31] ? 1'b1 : c_td;
                            n_h  = hgt_mag;
                            if (c_w[31] || c_w == 32'd0 || hgt_mag == 32'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = (c_off > bmprgb_pkg::HEADER_END) ? PH_SKIP
                                                                           : PH_PIXEL;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            PH_SKIP: begin
                if (c_bpos < c_off) begin
                    n_bpos  = c_bpos + 32'd1;
                    n_phase = (c_bpos + 32'd1 < c_off) ? PH_SKIP : PH_PIXEL;
                end else begin
                    n_phase = PH_PIXEL;
                    pix_go  = 1'b1;
                end
            end
            PH_PIXEL: pix_go = 1'b1;
            PH_PAD: begin
                if (c_bip > 2'd1) begin
                    n_bip = c_bip - 2'd1;
                end else begin
                    row_end = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_rej) begin
            n_phase = PH_REJECT;
            if (org_in) begin
                emit = 1'b1; e_kind = bmprgb_pkg::EV_REJECT; e_err = rej_code;
            end
        end

        if (pix_go) begin
            if (c_bip == 2'd0) begin
                n_pa = {8'h00, i_byte};
            end else if (c_bip == 2'd1) begin
                n_pa = {i_byte, c_pa[7:0]};
            end
            if (c_bip < need) begin
                n_bip = c_bip + 2'd1;
            end else begin
                n_bip    = 2'd0;
                // BGR888 -> RGB565; 16-bit data passes through
                px_color = c_deep ? {i_byte[7:3], c_pa[15:10], c_pa[7:3]} : n_pa;
                emit     = pix_in;
                if (bir_inc >= c_w) begin
                    if (pad != 2'd0) begin
                        n_bir   = 32'd0;
                        n_bip   = pad;
                        n_phase = PH_PAD;
                    end else begin
                        row_end = 1'b1;
                    end
                end else begin
                    n_bir = bir_inc;
                end
            end
        end

        if (row_end) begin
            n_bir   = 32'd0;
            n_bip   = 2'd0;
            n_frow  = c_frow + 32'd1;
            n_phase = (c_frow + 32'd1 >= c_h) ? PH_DONE : PH_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_bpos  <= '0; r_fa <= '0; r_off <= '0; r_w <= '0; r_h <= '0;
            r_td    <= 1'b0; r_deep <= 1'b0; r_pa <= '0; r_bip <= '0;
            r_bir   <= '0; r_frow <= '0;
            r_ctl   <= '0;
        end else if (i_adv) begin
            if (i_valid) begin
                r_phase <= n_phase; r_bpos <= n_bpos; r_fa <= n_fa; r_off <= n_off;
                r_w     <= n_w; r_h <= n_h; r_td <= n_td; r_deep <= n_deep;
                r_pa    <= n_pa; r_bip <= n_bip; r_bir <= n_bir; r_frow <= n_frow;
            end
            r_ctl.valid <= i_valid && emit;
            r_ctl.kind  <= e_kind;
            r_ctl.err   <= e_err;
            r_ctl.last  <= e_last;
            r_ctl.rot   <= i_cfg.rotation_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col   <= col_n;
            r_row   <= row_n;
            r_cw    <= cw;
            r_ch    <= ch;
            r_color <= px_color;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_cw    = r_cw;
    assign o_ch    = r_ch;
    assign o_color = r_color;

endmodule

[src/bmprgb_place.sv]
// Rotation and frame-buffer index multiply; holds the result register.
// Depends on bmprgb_pkg.
module bmprgb_place #(
    parameter int MAX_SIDE = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  bmprgb_pkg::t_mid              i_ctl,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_col,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_row,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_cw,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_ch,
    input  logic [15:0]                   i_color,
    output logic                          o_valid,
    output logic                          o_kind,
    output logic [1:0]                    o_err,
    output logic [13:0]                   o_index,
    output logic [15:0]                   o_color,
    output logic [7:0]                    o_cw,
    output logic [7:0]                    o_ch,
    output logic                          o_last
);

    localparam int CW = $clog2(MAX_SIDE + 1);

    logic [CW-1:0]   rr, cc;
    logic [2*CW-1:0] prod;
    logic [2*CW:0]   sum;
    logic            pix;

    logic        r_valid, r_kind, r_last;
    logic [1:0]  r_err;
    logic [13:0] r_index;
    logic [15:0] r_color;
    logic [7:0]  r_cw, r_ch;

    always_comb begin
        unique case (i_ctl.rot)
            bmprgb_pkg::ROT_90: begin
                rr = i_col;                    cc = i_ch - CW'(1) - i_row;
            end
            bmprgb_pkg::ROT_180: begin
                rr = i_ch - CW'(1) - i_row;    cc = i_cw - CW'(1) - i_col;
            end
            bmprgb_pkg::ROT_270: begin
                rr = i_cw - CW'(1) - i_col;    cc = i_row;
            end
            default: begin
                rr = i_row;                    cc = i_col;
            end
        endcase
        prod = rr * i_cw;
        sum  = {1'b0, prod} + (2*CW+1)'(cc);
        pix  = (i_ctl.kind == bmprgb_pkg::EV_PIXEL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    // a rejection carries only its kind and code
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_kind  <= i_ctl.kind;
            r_err   <= pix ? bmprgb_pkg::ERR_NONE : i_ctl.err;
            r_index <= pix ? 14'(sum) : 14'd0;
            r_color <= pix ? i_color : 16'd0;
            r_cw    <= pix ? 8'(i_cw) : 8'd0;
            r_ch    <= pix ? 8'(i_ch) : 8'd0;
            r_last  <= pix && i_ctl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_err   = r_err;
    assign o_index = r_index;
    assign o_color = r_color;
    assign o_cw    = r_cw;
    assign o_ch    = r_ch;
    assign o_last  = r_last;

endmodule

[src/bmprgb_chk.sv]
// Port-level checks for the BMP stream to rotated RGB565 top level.
// Bound to bmp_stream_to_rotated_rgb565_top; no package dependencies.
module bmprgb_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // a waiting result is neither dropped nor changed
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // rejection: nonzero code, all pixel fields clear
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            o_m_axis_tdata[1:0] != 2'd0 && o_m_axis_tdata[47:2] == 46'd0 && !o_m_axis_tlast)
        else $error("malformed rejection");

    // pixel write: no error code
    a_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[1:0] == 2'd0)
        else $error("pixel write with error code");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind bmp_stream_to_rotated_rgb565_top bmprgb_chk u_bmprgb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
